// ===== rtl/bbps_pkg.sv =====
`default_nettype none

package bbps_pkg;

	localparam int KEY_W      = 32;
	localparam int ADDR_W     = 12;
	localparam int EIU_W      = 13;
	localparam int RES_W      = 13;
	// Wide enough for a child number 0..KEYS_PER_BLOCK at the largest block size.
	localparam int LANE_MAX_W = 6;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// Outcome of scanning one block against the query key.
	typedef struct packed {
		logic                  eq_hit;
		logic [LANE_MAX_W-1:0] child;
	} bbps_scan_t;

endpackage

`default_nettype wire

// ===== rtl/bbps_key_mem.sv =====
`default_nettype none

module bbps_key_mem #(
	parameter int KEYS_PER_BLOCK = 8,
	parameter int ROWS           = 512,
	parameter int ROW_W          = 9,
	parameter int LANE_W         = 3
) (
	input  wire logic                                          clk,
	input  wire logic                                          wr_en,
	input  wire logic [ROW_W-1:0]                              wr_row,
	input  wire logic [LANE_W-1:0]                             wr_lane,
	input  wire logic [bbps_pkg::KEY_W-1:0]                    wr_key,
	input  wire logic                                          rd_en,
	input  wire logic [ROW_W-1:0]                              rd_row,
	output logic      [KEYS_PER_BLOCK-1:0][bbps_pkg::KEY_W-1:0] rd_data
);

	logic [KEYS_PER_BLOCK-1:0][bbps_pkg::KEY_W-1:0] mem [ROWS];

	// One row holds a whole block; a write touches a single key lane of it.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_row][wr_lane] <= wr_key;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_row];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/bbps_block_eval.sv =====
`default_nettype none

module bbps_block_eval #(
	parameter int KEYS_PER_BLOCK = 8,
	parameter int STORE_DEPTH    = 4096,
	parameter int POS_W          = 17
) (
	input  wire logic [KEYS_PER_BLOCK-1:0][bbps_pkg::KEY_W-1:0] keys,
	input  wire logic [bbps_pkg::KEY_W-1:0]                     query,
	input  wire logic [POS_W-1:0]                               pos,
	output bbps_pkg::bbps_scan_t                                scan
);

	logic [KEYS_PER_BLOCK-1:0] lane_lt;
	logic [KEYS_PER_BLOCK-1:0] lane_eq;

	for (genvar i = 0; i < KEYS_PER_BLOCK; i++) begin : g_lane
		logic [31:0] idx;
		logic        beyond;
		assign idx    = 32'(pos) + 32'(i);
		// Positions past the end of the store act as keys above any query.
		assign beyond = idx >= 32'(STORE_DEPTH);
		assign lane_lt[i] = !beyond && ($signed(keys[i]) < $signed(query));
		assign lane_eq[i] = !beyond && (keys[i] == query);
	end

	// The first lane that is not below the query decides the block.
	always_comb begin
		logic found;
		found       = 1'b0;
		scan.eq_hit = 1'b0;
		scan.child  = bbps_pkg::LANE_MAX_W'(KEYS_PER_BLOCK);
		for (int i = 0; i < KEYS_PER_BLOCK; i++) begin
			if (!found && !lane_lt[i]) begin
				found       = 1'b1;
				scan.child  = bbps_pkg::LANE_MAX_W'(i);
				scan.eq_hit = lane_eq[i];
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/blocked_bfs_predecessor_search.sv =====
// Predecessor search over a key store kept in breadth-first blocked search-tree
// layout, KEYS_PER_BLOCK keys to a block. A beat with kind 0 writes one key: it
// is accepted, its row and lane come from a divide-by-block-size step, then the
// key is written into one lane of its row. A beat with kind 1 walks the tree
// from the root and returns one result_index: the index of an equal key, else
// of the largest key below the query on the path, else -1. At each tree level a
// whole block row is read from the key memory, then all of its keys are compared
// at once and the child is picked. One item is in flight at a time; a finished
// result waits in an output register while the next beat is accepted, and a
// later query holds in its finishing state for as long as that result is
// stalled. The user must write entries_in_use through cfg_wr_en only while the
// block is idle; the block itself does not enforce this. Keys that were never
// written read back as unknown values.
`default_nettype none

module blocked_bfs_predecessor_search #(
	parameter int KEYS_PER_BLOCK = 8,
	parameter int STORE_DEPTH    = 4096
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wr_en,
	input  wire logic [bbps_pkg::EIU_W-1:0]      cfg_wr_data,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic                            kind,
	input  wire logic [bbps_pkg::ADDR_W-1:0]     address,
	input  wire logic [bbps_pkg::KEY_W-1:0]      key,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic signed [bbps_pkg::RES_W-1:0]    result_index
);

	localparam int ROWS   = (STORE_DEPTH + KEYS_PER_BLOCK - 1) / KEYS_PER_BLOCK;
	localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int LANE_W = (KEYS_PER_BLOCK > 1) ? $clog2(KEYS_PER_BLOCK) : 1;
	localparam int POS_W  = bbps_pkg::EIU_W + $clog2(KEYS_PER_BLOCK + 1) + 1;
	localparam int MUL_W  = 2 * bbps_pkg::ADDR_W + 1;
	localparam int RECIP  = (1 << bbps_pkg::ADDR_W) / KEYS_PER_BLOCK;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_WDIV  = 3'd1;
	localparam logic [2:0] ST_WPUT  = 3'd2;
	localparam logic [2:0] ST_CHECK = 3'd3;
	localparam logic [2:0] ST_EVAL  = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0]                        state_q;
	logic [bbps_pkg::EIU_W-1:0]        eiu_q;
	logic [bbps_pkg::ADDR_W-1:0]       addr_q;
	logic [bbps_pkg::KEY_W-1:0]        key_q;
	logic [bbps_pkg::ADDR_W-1:0]       quot_q;
	logic [POS_W-1:0]                  block_q;
	logic [POS_W-1:0]                  pos_q;
	logic signed [bbps_pkg::RES_W-1:0] ans_q;
	logic                              out_valid_q;
	logic signed [bbps_pkg::RES_W-1:0] result_q;

	logic                                           in_acc;
	logic                                           in_range;
	logic [31:0]                                    limit;
	logic                                           walk_on;
	logic [MUL_W-1:0]                               div_prod;
	logic [31:0]                                    rem0;
	logic                                           rem_fix;
	logic [31:0]                                    row32;
	logic [31:0]                                    lane32;
	logic [31:0]                                    blk32;
	logic                                           wr_en;
	logic                                           rd_en;
	logic [KEYS_PER_BLOCK-1:0][bbps_pkg::KEY_W-1:0] rd_data;
	bbps_pkg::bbps_scan_t                           scan;
	logic [POS_W-1:0]                               child_w;
	logic [POS_W-1:0]                               pos_hit;
	logic [POS_W-1:0]                               block_nx;
	logic [POS_W-1:0]                               pos_nx;
	logic                                           out_free;

	assign in_stall     = (state_q != ST_IDLE);
	assign in_acc       = in_valid && !in_stall;
	assign in_range     = 32'(address) < 32'(STORE_DEPTH);
	assign out_valid    = out_valid_q;
	assign result_index = result_q;
	assign out_free     = !out_valid_q || !out_stall;

	assign limit   = (32'(eiu_q) > 32'(STORE_DEPTH)) ? 32'(STORE_DEPTH) : 32'(eiu_q);
	assign walk_on = 32'(pos_q) < limit;

	// Row and lane of a write address: reciprocal multiply, then one correction.
	assign div_prod = MUL_W'(addr_q) * MUL_W'(RECIP);
	assign rem0     = 32'(addr_q) - 32'(quot_q) * 32'(KEYS_PER_BLOCK);
	assign rem_fix  = rem0 >= 32'(KEYS_PER_BLOCK);
	assign row32    = rem_fix ? 32'(quot_q) + 32'd1 : 32'(quot_q);
	assign lane32   = rem_fix ? rem0 - 32'(KEYS_PER_BLOCK) : rem0;

	assign wr_en = (state_q == ST_WPUT);
	assign rd_en = (state_q == ST_CHECK) && walk_on;
	assign blk32 = 32'(block_q);

	bbps_key_mem #(
		.KEYS_PER_BLOCK (KEYS_PER_BLOCK),
		.ROWS           (ROWS),
		.ROW_W          (ROW_W),
		.LANE_W         (LANE_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_row  (row32[ROW_W-1:0]),
		.wr_lane (lane32[LANE_W-1:0]),
		.wr_key  (key_q),
		.rd_en   (rd_en),
		.rd_row  (blk32[ROW_W-1:0]),
		.rd_data (rd_data)
	);

	bbps_block_eval #(
		.KEYS_PER_BLOCK (KEYS_PER_BLOCK),
		.STORE_DEPTH    (STORE_DEPTH),
		.POS_W          (POS_W)
	) u_eval (
		.keys  (rd_data),
		.query (key_q),
		.pos   (pos_q),
		.scan  (scan)
	);

	// The first key position of the next block is kept alongside its number.
	assign child_w  = POS_W'(scan.child);
	assign pos_hit  = pos_q + child_w;
	assign block_nx = block_q * POS_W'(KEYS_PER_BLOCK + 1) + POS_W'(1) + child_w;
	assign pos_nx   = pos_q * POS_W'(KEYS_PER_BLOCK + 1)
		+ POS_W'(KEYS_PER_BLOCK) * (POS_W'(1) + child_w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			eiu_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				eiu_q <= cfg_wr_data;
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (kind == bbps_pkg::KIND_QUERY) begin
							state_q <= ST_CHECK;
						end else if (in_range) begin
							state_q <= ST_WDIV;
						end
					end
				end
				ST_WDIV:  state_q <= ST_WPUT;
				ST_WPUT:  state_q <= ST_IDLE;
				ST_CHECK: state_q <= walk_on ? ST_EVAL : ST_DONE;
				ST_EVAL:  state_q <= scan.eq_hit ? ST_DONE : ST_CHECK;
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			addr_q  <= address;
			key_q   <= key;
			block_q <= '0;
			pos_q   <= '0;
			ans_q   <= '1;
		end
		if (state_q == ST_WDIV) begin
			quot_q <= div_prod[bbps_pkg::ADDR_W +: bbps_pkg::ADDR_W];
		end
		if (state_q == ST_EVAL) begin
			if (scan.eq_hit) begin
				ans_q <= bbps_pkg::RES_W'(pos_hit);
			end else begin
				if (scan.child != '0) begin
					ans_q <= bbps_pkg::RES_W'(pos_hit - POS_W'(1));
				end
				block_q <= block_nx;
				pos_q   <= pos_nx;
			end
		end
		if (state_q == ST_DONE && out_free) begin
			result_q <= ans_q;
		end
	end

	a_eval_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EVAL |-> $past(state_q) == ST_CHECK && $past(walk_on))
		else $error("block evaluated without a row read in the cycle before");

	a_pos_tracks_block: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CHECK |-> 32'(pos_q) == 32'(block_q) * 32'(KEYS_PER_BLOCK))
		else $error("block start position out of step with block number");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_DONE)
		else $error("result beat raised outside the finishing state");

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && rd_en))
		else $error("key memory read and written in the same cycle");

endmodule

`default_nettype wire

// ===== bench/bbps_search_checker.sv =====
module bbps_search_checker #(
	parameter int KEYS_PER_BLOCK = 8,
	parameter int STORE_DEPTH    = 4096
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [bbps_pkg::EIU_W-1:0]        cfg_wr_data,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic                              kind,
	input  logic [bbps_pkg::ADDR_W-1:0]       address,
	input  logic [bbps_pkg::KEY_W-1:0]        key,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic signed [bbps_pkg::RES_W-1:0] result_index,
	output int                                mismatches,
	output int                                awaiting
);
	timeunit 1ns;
	timeprecision 1ps;

	logic signed [bbps_pkg::KEY_W-1:0] key_mem [STORE_DEPTH];
	logic [bbps_pkg::EIU_W-1:0]        tree_entries = '0;
	logic signed [bbps_pkg::RES_W-1:0] pending_results [$];
	int                                error_count = 0;
	int                                backlog = 0;

	assign mismatches = error_count;
	assign awaiting = backlog;

	// Walks the blocked tree from the root the same way the hardware does: within a
	// block, stop at an equal key or at the first key above the query.
	function automatic logic signed [bbps_pkg::RES_W-1:0] predecessor_index(
		input logic signed [bbps_pkg::KEY_W-1:0] q
	);
		int limit;
		int blk;
		int nxt;
		int idx;
		int best;
		limit = (tree_entries > STORE_DEPTH) ? STORE_DEPTH : int'(tree_entries);
		blk = 0;
		best = -1;
		while (blk * KEYS_PER_BLOCK < limit) begin
			nxt = 0;
			for (int i = 0; i < KEYS_PER_BLOCK; i++) begin
				idx = blk * KEYS_PER_BLOCK + i;
				if (idx < STORE_DEPTH && key_mem[idx] == q)
					return bbps_pkg::RES_W'(idx);
				// Slots past the end of the store behave as keys above any query.
				if (idx >= STORE_DEPTH || key_mem[idx] > q) begin
					if (i > 0)
						best = idx - 1;
					nxt = blk * (KEYS_PER_BLOCK + 1) + 1 + i;
					break;
				end
				best = idx;
				if (i == KEYS_PER_BLOCK - 1)
					nxt = blk * (KEYS_PER_BLOCK + 1) + 1 + KEYS_PER_BLOCK;
			end
			blk = nxt;
		end
		return bbps_pkg::RES_W'(best);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic signed [bbps_pkg::RES_W-1:0] want;
		if (!arst_n) begin
			tree_entries = '0;
			pending_results.delete();
			backlog = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					error_count++;
					$display("%0t: unexpected result beat, expected none, got %0d",
						$time, result_index);
				end else begin
					want = pending_results.pop_front();
					if (result_index !== want) begin
						error_count++;
						$display("%0t: result_index mismatch, expected %0d, got %0d",
							$time, want, result_index);
					end
				end
			end
			if (cfg_wr_en)
				tree_entries = cfg_wr_data;
			if (in_valid && !in_stall) begin
				if (kind == bbps_pkg::KIND_WRITE) begin
					if (address < STORE_DEPTH)
						key_mem[address] = key;
				end else begin
					pending_results.push_back(predecessor_index(key));
				end
			end
			backlog = pending_results.size();
		end
	end

endmodule

// ===== bench/tb_blocked_bfs_predecessor_search.sv =====
module tb_blocked_bfs_predecessor_search;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int KPB            = 8;
	localparam int DEPTH          = 4096;
	localparam int RANDOM_ITEMS   = 1200;
	localparam int TAIL_ITEMS     = 250;
	localparam int IDLE_GAP       = 40;
	localparam int HOLD_CYCLES    = 250;
	localparam int WATCHDOG_LIMIT = 2000;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              cfg_wr_en = 1'b0;
	logic [bbps_pkg::EIU_W-1:0]        cfg_wr_data = '0;
	logic                              in_valid = 1'b0;
	logic                              kind = bbps_pkg::KIND_WRITE;
	logic [bbps_pkg::ADDR_W-1:0]       address = '0;
	logic [bbps_pkg::KEY_W-1:0]        key = '0;
	logic                              out_stall = 1'b0;
	logic                              in_stall;
	logic                              out_valid;
	logic signed [bbps_pkg::RES_W-1:0] result_index;
	int                                mismatches;
	int                                awaiting;

	bit                                hold_off_req = 1'b0;
	int                                burst_left = 0;
	int                                quiet_cycles = 0;
	int                                n_writes = 0;
	int                                n_queries = 0;
	int                                n_cfg = 0;

	logic [bbps_pkg::KEY_W-1:0]        sorted_keys [DEPTH];
	logic [bbps_pkg::KEY_W-1:0]        layout_keys [DEPTH];
	int                                sort_pos;

	always #4 clk = ~clk;

	blocked_bfs_predecessor_search #(
		.KEYS_PER_BLOCK(KPB),
		.STORE_DEPTH   (DEPTH)
	) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.address     (address),
		.key         (key),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_index(result_index)
	);

	bbps_search_checker #(
		.KEYS_PER_BLOCK(KPB),
		.STORE_DEPTH   (DEPTH)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.address     (address),
		.key         (key),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_index(result_index),
		.mismatches  (mismatches),
		.awaiting    (awaiting)
	);

	// Offers one beat and returns at the edge that accepts it. Beats go out in bursts;
	// each new burst opens with a gap with valid low, which may be empty.
	task automatic push_item(input logic k, input logic [bbps_pkg::ADDR_W-1:0] a,
		input logic [bbps_pkg::KEY_W-1:0] v);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 25) : $urandom_range(0, 4);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b1;
		kind <= k;
		address <= a;
		key <= v;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		burst_left--;
		if (k == bbps_pkg::KIND_WRITE)
			n_writes++;
		else
			n_queries++;
	endtask

	// Stops offering beats until every predicted result has come out, then lets the
	// block finish any write still in flight.
	task automatic wait_idle();
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (awaiting != 0)
			@(posedge clk);
		repeat (IDLE_GAP) @(posedge clk);
	endtask

	task automatic write_entries(input logic [bbps_pkg::EIU_W-1:0] v);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		n_cfg++;
	endtask

	// Hands out ascending keys in the in-order sequence of the blocked tree, so that
	// the layout is a valid search tree.
	function automatic void place_subtree(input int blk, input int nblk);
		int child;
		for (int i = 0; i <= KPB; i++) begin
			child = blk * (KPB + 1) + 1 + i;
			if (child < nblk)
				place_subtree(child, nblk);
			if (i < KPB) begin
				layout_keys[blk * KPB + i] = sorted_keys[sort_pos];
				sort_pos++;
			end
		end
	endfunction

	task automatic load_tree(input int region, input bit narrow);
		longint      acc;
		int unsigned stride;
		int          pads;
		if (narrow) begin
			// Tight spacing gives many duplicate keys.
			stride = $urandom_range(0, 3);
			acc = -longint'($urandom_range(0, 60));
		end else begin
			stride = 32'hFFFF_FFFF / (region + 1);
			acc = -64'sd2147483648 + $urandom_range(0, stride);
		end
		for (int i = 0; i < region; i++) begin
			acc = acc + $urandom_range(0, stride);
			sorted_keys[i] = acc[bbps_pkg::KEY_W-1:0];
		end
		if ($urandom_range(0, 3) == 0)
			sorted_keys[0] = 32'h8000_0000;
		pads = $urandom_range(0, KPB);
		for (int j = 0; j < pads && j < region; j++)
			sorted_keys[region - 1 - j] = 32'h7FFF_FFFF;
		sort_pos = 0;
		place_subtree(0, region / KPB);
		for (int i = 0; i < region; i++)
			push_item(bbps_pkg::KIND_WRITE, bbps_pkg::ADDR_W'(i), layout_keys[i]);
	endtask

	function automatic logic [bbps_pkg::KEY_W-1:0] pick_query(input int region);
		int                         roll;
		logic [bbps_pkg::KEY_W-1:0] near;
		roll = $urandom_range(0, 99);
		if (region == 0 || roll >= 90)
			return $urandom();
		near = layout_keys[$urandom_range(0, region - 1)];
		if (roll < 45)
			return near;
		if (roll < 65)
			return ($urandom_range(0, 1) != 0) ? near + 1 : near - 1;
		if (roll < 85)
			return near + $urandom_range(0, 2000) - 1000;
		return ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
	endfunction

	task automatic run_phase(input int entries, input int n_items, input bit reload,
		input bit narrow, input bit with_hold);
		int region;
		write_entries(bbps_pkg::EIU_W'(entries));
		region = ((entries > DEPTH ? DEPTH : entries) + KPB - 1) / KPB * KPB;
		if (reload && region > 0)
			load_tree(region, narrow);
		if (with_hold)
			hold_off_req = 1'b1;
		for (int i = 0; i < n_items; i++) begin
			if (i == n_items / 2 && $urandom_range(0, 2) == 0)
				wait_idle();
			// Stray writes land anywhere and may break the tree; queries stay legal since
			// the whole tree region is already written.
			if ($urandom_range(0, 99) < 8)
				push_item(bbps_pkg::KIND_WRITE,
					bbps_pkg::ADDR_W'($urandom_range(0, DEPTH - 1)), $urandom());
			else
				push_item(bbps_pkg::KIND_QUERY,
					bbps_pkg::ADDR_W'($urandom_range(0, DEPTH - 1)), pick_query(region));
		end
	endtask

	// Keys of the leftmost path: deeper blocks hold smaller keys, as in-order demands.
	function automatic logic [bbps_pkg::KEY_W-1:0] path_key(input int lvl, input int lane);
		return bbps_pkg::KEY_W'(-10000 * lvl + 100 * lane);
	endfunction

	// Loads only the leftmost root-to-leaf path of a tree that spans the whole store.
	// Every query either equals a key on that path or lies below the first key of the
	// block above the deepest one, so the walk never leaves the path and only the
	// store's size ends it when the entry count reaches or passes the store's end.
	task automatic path_check(input int n_per_size);
		int                         path_blk [8];
		int                         sizes [3];
		int                         levels;
		int                         blk;
		int                         lvl;
		logic [bbps_pkg::KEY_W-1:0] q;
		sizes[0] = DEPTH;
		sizes[1] = (1 << bbps_pkg::EIU_W) - 1;
		sizes[2] = DEPTH - 1;
		levels = 0;
		blk = 0;
		while (blk * KPB < DEPTH && levels < 8) begin
			path_blk[levels] = blk;
			levels++;
			blk = blk * (KPB + 1) + 1;
		end
		for (int l = 0; l < levels; l++)
			for (int j = 0; j < KPB; j++)
				push_item(bbps_pkg::KIND_WRITE, bbps_pkg::ADDR_W'(path_blk[l] * KPB + j),
					path_key(l, j));
		for (int s = 0; s < 3; s++) begin
			write_entries(bbps_pkg::EIU_W'(sizes[s]));
			for (int i = 0; i < n_per_size; i++) begin
				if ($urandom_range(0, 99) < 40) begin
					lvl = $urandom_range(0, levels - 1);
					q = path_key(lvl, $urandom_range(0, KPB - 1));
				end else begin
					q = path_key(levels - 2, 0) - $urandom_range(0, 12000);
				end
				push_item(bbps_pkg::KIND_QUERY,
					bbps_pkg::ADDR_W'($urandom_range(0, DEPTH - 1)), q);
			end
		end
	endtask

	// The receiver changes its stall rate now and then, including stretches with no
	// stall at all, and holds off completely once when asked.
	initial begin
		int pct;
		int left;
		pct = 0;
		left = 0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end
			if (left == 0) begin
				left = $urandom_range(20, 300);
				case ($urandom_range(0, 3))
					0: pct = 0;
					1: pct = 25;
					2: pct = 60;
					default: pct = 90;
				endcase
			end
			left--;
			out_stall <= ($urandom_range(0, 99) < pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		int entries;
		int roll;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Empty tree: every query misses, whatever the key.
		write_entries('0);
		push_item(bbps_pkg::KIND_QUERY, '0, 32'h8000_0000);
		push_item(bbps_pkg::KIND_QUERY, '1, 32'h7FFF_FFFF);
		push_item(bbps_pkg::KIND_QUERY, 12'hA5A, '0);

		// A single block whose first slot holds the lowest key and whose last is padding.
		write_entries(bbps_pkg::EIU_W'(KPB));
		for (int i = 0; i < KPB; i++) begin
			if (i == 0)
				push_item(bbps_pkg::KIND_WRITE, bbps_pkg::ADDR_W'(i), 32'h8000_0000);
			else if (i == KPB - 1)
				push_item(bbps_pkg::KIND_WRITE, bbps_pkg::ADDR_W'(i), 32'h7FFF_FFFF);
			else
				push_item(bbps_pkg::KIND_WRITE, bbps_pkg::ADDR_W'(i),
					bbps_pkg::KEY_W'((i - KPB / 2) * 100));
		end
		push_item(bbps_pkg::KIND_WRITE, bbps_pkg::ADDR_W'(DEPTH - 1), '0);
		push_item(bbps_pkg::KIND_QUERY, '0, 32'h8000_0000);
		push_item(bbps_pkg::KIND_QUERY, '0, 32'h8000_0001);
		push_item(bbps_pkg::KIND_QUERY, '0, -32'sd250);
		push_item(bbps_pkg::KIND_QUERY, '0, '0);
		push_item(bbps_pkg::KIND_QUERY, '0, 32'd50);
		push_item(bbps_pkg::KIND_QUERY, '0, 32'd250);
		push_item(bbps_pkg::KIND_QUERY, '0, 32'h7FFF_FFFE);
		push_item(bbps_pkg::KIND_QUERY, '0, 32'h7FFF_FFFF);

		while (n_writes + n_queries < RANDOM_ITEMS - TAIL_ITEMS) begin
			roll = $urandom_range(0, 99);
			if (roll < 5)
				entries = 0;
			else if (roll < 82)
				entries = $urandom_range(1, 90);
			else
				entries = $urandom_range(91, 250);
			run_phase(entries, $urandom_range(40, 90), 1'b1, $urandom_range(0, 2) == 0,
				n_cfg == 3);
		end

		// One path of a full-size tree under sizes just below, at and past the store's end,
		// then an empty tree again.
		path_check(30);
		run_phase(0, 10, 1'b0, 1'b0, 1'b0);

		wait_idle();
		$display("Covered %0d key writes and %0d predecessor queries over %0d tree sizes,",
			n_writes, n_queries, n_cfg);
		$display("from an empty tree to entry counts at and past the end of the store.");
		if (mismatches == 0 && awaiting == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/bbps_pkg.sv
rtl/bbps_key_mem.sv
rtl/bbps_block_eval.sv
rtl/blocked_bfs_predecessor_search.sv
bench/bbps_search_checker.sv
bench/tb_blocked_bfs_predecessor_search.sv
